@@ sv/plsu_pkg.sv @@
// ----------------------------------------------------------------------------
// plsu_pkg
// Command, status and cell control types for the positional list store.
// ----------------------------------------------------------------------------
package plsu_pkg;

    localparam int CMD_W      = 3;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 5;
    localparam int CNT_PORT_W = 5;
    localparam int ST_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_READ       = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     extract;
    } cell_ctrl_t;

endpackage

@@ sv/plsu_cell.sv @@
// ----------------------------------------------------------------------------
// plsu_cell
// One list entry: hold, take the left neighbour or the new value on insert, take the
// right neighbour on remove, and register its value when picked for extraction.
// ----------------------------------------------------------------------------
module plsu_cell #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  plsu_pkg::cell_ctrl_t         ctrl,
    input  logic [$clog2(CAPACITY)-1:0]  tgt,
    input  logic [DATA_WIDTH-1:0]        value_in,
    input  logic [DATA_WIDTH-1:0]        left_data,
    input  logic [DATA_WIDTH-1:0]        right_data,
    output logic [DATA_WIDTH-1:0]        data,
    output logic [DATA_WIDTH-1:0]        pick
);
    import plsu_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] pick_reg;
    logic [DATA_WIDTH-1:0] pick_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (MY_IDX > tgt)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == tgt)
                begin
                    data_next = value_in;
                end
            end
            OP_REMOVE:
            begin
                if (MY_IDX >= tgt)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
        // zero unless this entry is the one read or taken out
        pick_next = (ctrl.extract && (MY_IDX == tgt)) ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        pick_reg <= pick_next;
    end

    assign data = data_reg;
    assign pick = pick_reg;

endmodule

@@ sv/positional_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list held in a chain of entry cells.
// The result strobe (done) rises in the cycle after the request is taken.
// Throughput: one request per cycle; every cell shifts or holds in the same
// cycle and the count register settles in that cycle too.
// Reset: the count clears at once; entry contents stay undefined until written.
// Results are shown for exactly one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [plsu_pkg::CMD_W-1:0]              cmd,
    input  logic signed [plsu_pkg::VAL_W-1:0]       value,
    input  logic [plsu_pkg::POS_W-1:0]              position,
    output logic                                    done,
    output logic signed [plsu_pkg::VAL_W-1:0]       read_value,
    output logic [plsu_pkg::CNT_PORT_W-1:0]         count,
    output logic [plsu_pkg::ST_W-1:0]               status
);
    import plsu_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // common width for comparing the position port with the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic                  accept;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    status_t               status_reg;
    status_t               status_next;

    cell_ctrl_t            ctrl;
    logic [IDX_W-1:0]      tgt;
    logic [DATA_WIDTH-1:0] store_value;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  is_full;
    logic                  is_empty;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_pick [CAPACITY];
    logic [DATA_WIDTH-1:0] picked;

    // The list keeps pace with the request stream, so a request is never held off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Keep only the low DATA_WIDTH bits of the request value, zero above 32 bits.
    assign store_value = DATA_WIDTH'($unsigned(value));

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    // Decode the request into one broadcast for the chain.  A rejected
    // request leaves every cell holding and the count unchanged.
    always_comb
    begin
        ctrl.op      = OP_HOLD;
        ctrl.extract = 1'b0;
        tgt          = IDX_W'(position);
        status_next  = ST_DONE;
        count_next   = count_reg;
        if (accept)
        begin
            unique case (cmd_t'(cmd))
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = OP_INSERT;
                        tgt        = '0;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = OP_INSERT;
                        tgt        = count_reg[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    // full takes precedence over a bad position
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (pos_ext > cnt_ext)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.op    = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.op      = OP_REMOVE;
                        ctrl.extract = 1'b1;
                        tgt          = '0;
                        count_next   = count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.op      = OP_REMOVE;
                        ctrl.extract = 1'b1;
                        tgt          = IDX_W'(count_reg - 1'b1);
                        count_next   = count_reg - 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.op      = OP_REMOVE;
                        ctrl.extract = 1'b1;
                        count_next   = count_reg - 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.extract = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    // drop every entry: only the count needs to move
                    count_next = '0;
                end
            endcase
        end
    end

    // Chain of entry cells: each sees its left and right neighbour.
    // Cell 0 never takes from the left; the last cell refills with itself.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plsu_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .tgt        (tgt),
            .value_in   (store_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .pick       (cell_pick[i])
        );
    end

    // At most one cell holds a non-zero pick, so an OR gathers it.
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            picked = picked | cell_pick[i];
        end
    end

    // Sign-extend the picked entry to the 32-bit result, or keep its low bits.
    if (DATA_WIDTH >= VAL_W)
    begin : g_rv_wide
        assign read_value = signed'(picked[VAL_W-1:0]);
    end
    else
    begin : g_rv_narrow
        assign read_value = signed'({{(VAL_W - DATA_WIDTH){picked[DATA_WIDTH-1]}}, picked});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    assign done   = done_reg;
    assign count  = CNT_PORT_W'(count_reg);
    assign status = status_reg;

endmodule

@@ test/tb_positional_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// tb_positional_list_store_unit
// Self-checking bench for the positional list store. Each accepted request is
// replayed on a private copy of the list to predict its reply (value, count,
// status). Every reply strobe is compared field by field with the oldest
// prediction. Stimulus opens with the corner cases: empty list, full list,
// positions at and past the end, and extreme values. It then runs random
// grow and shrink phases under different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_positional_list_store_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import plsu_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int STALL_LIMIT = 2000;

    // One predicted reply per accepted request
    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_PORT_W-1:0]   count;
        status_t                 status;
    } list_reply_t;

    // ------------------------------------------------------------------------
    // Reply tracker: keeps a shadow of the list contents and the fill count,
    // predicts the reply of every accepted request and checks the replies
    // that come back in order.
    // ------------------------------------------------------------------------
    class list_reply_tracker;
        logic signed [VAL_W-1:0] entries [CAPACITY];
        int                      fill;
        list_reply_t             pending_replies [$];
        int                      failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        // Take out the entry at pos and close the gap behind it
        function logic signed [VAL_W-1:0] take_entry(int pos);
            logic signed [VAL_W-1:0] taken;
            taken = entries[pos];
            for (int i = pos; i + 1 < fill; i++)
                entries[i] = entries[i + 1];
            fill--;
            return taken;
        endfunction

        function void note_request(cmd_t op, logic signed [VAL_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            list_reply_t reply;
            int          slot;
            reply.read_value = '0;
            reply.status     = ST_DONE;
            case (op)
                CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT:
                begin
                    // Full check wins over the position check for insert
                    if (fill >= CAPACITY)
                        reply.status = ST_FULL;
                    else if (op == CMD_INSERT && pos > fill)
                        reply.status = ST_RANGE;
                    else
                    begin
                        slot = (op == CMD_PUSH_FRONT) ? 0 :
                               (op == CMD_PUSH_BACK)  ? fill : int'(pos);
                        for (int i = fill; i > slot; i--)
                            entries[i] = entries[i - 1];
                        entries[slot] = val;
                        fill++;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (fill == 0)
                        reply.status = ST_RANGE;
                    else
                        reply.read_value =
                            take_entry(op == CMD_POP_FRONT ? 0 : fill - 1);
                end
                CMD_REMOVE:
                begin
                    if (pos >= fill)
                        reply.status = ST_RANGE;
                    else
                        reply.read_value = take_entry(pos);
                end
                CMD_READ:
                begin
                    if (pos >= fill)
                        reply.status = ST_RANGE;
                    else
                        reply.read_value = entries[pos];
                end
                default:
                    fill = 0;
            endcase
            reply.count = fill[CNT_PORT_W-1:0];
            pending_replies.insert(pending_replies.size(), reply);
        endfunction

        function void check_reply(logic signed [VAL_W-1:0] got_value,
                                  logic [CNT_PORT_W-1:0] got_count,
                                  logic [ST_W-1:0] got_status);
            list_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("reply strobe with no request outstanding");
                failures++;
                return;
            end
            want = pending_replies[0];
            pending_replies.delete(0);
            if (got_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d", want.read_value, got_value);
                failures++;
            end
            if (got_count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got_count);
                failures++;
            end
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                failures++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    done;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_PORT_W-1:0]   count;
    logic [ST_W-1:0]         status;

    list_reply_tracker tracker;
    int                stall_cycles;
    bit                growing;

    positional_list_store_unit #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .done       (done),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Check every reply in the cycle its strobe is up
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            tracker.check_reply(read_value, count, status);
    end

    // Watchdog: abandon the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Drive one request from a falling edge and hold it until the block takes
    // it. With probability idle_pct the sender first drops start for a random idle
    // gap; start is only ever assigned once per falling edge.
    task automatic issue_request(input cmd_t op, input logic signed [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos, input int idle_pct);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        cmd      <= op;
        value    <= val;
        position <= pos;
        // Advance edge by edge until the block is free to take the request
        do @(posedge clk); while (busy !== 1'b0);
        tracker.note_request(op, val, pos);
    endtask

    // Drop start and hold off until every outstanding reply has come back
    task automatic drain_replies();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Mostly random 32-bit values, with the extremes thrown in now and then
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Random phase. The list alternates between grow and shrink spells so
    // that it regularly reaches both full and empty. Most positions are
    // legal for the current count; the rest are anywhere from 0 to CAPACITY.
    task automatic run_random(input int items, input int idle_pct);
        cmd_t op;
        int   roll;
        int   pos;
        int   held;
        for (int n = 0; n < items; n++)
        begin
            if (n % 40 == 0)
                growing = $urandom_range(1);
            held = tracker.fill;
            roll = $urandom_range(99);
            if (roll < 2)
                op = CMD_CLEAR;
            else if (roll < 10)
                op = cmd_t'($urandom_range(CMD_CLEAR));
            else if (roll < (growing ? 70 : 35))
                op = cmd_t'($urandom_range(CMD_INSERT, CMD_PUSH_FRONT));
            else
                op = cmd_t'($urandom_range(CMD_READ, CMD_POP_FRONT));
            if ($urandom_range(99) < 85)
            begin
                if (op == CMD_INSERT)
                    pos = $urandom_range(held, 0);
                else
                    pos = (held > 0) ? $urandom_range(held - 1, 0) : 0;
            end
            else
                pos = $urandom_range(CAPACITY, 0);
            issue_request(op, pick_value(), pos[POS_W-1:0], idle_pct);
        end
    endtask

    initial
    begin
        tracker      = new();
        stall_cycles = 0;
        growing      = 1'b1;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_READ;
        value        = '0;
        position     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list: every take and every look must be refused
        issue_request(CMD_READ,      '0, 5'd0, 0);
        issue_request(CMD_POP_FRONT, '0, 5'd0, 0);
        issue_request(CMD_POP_BACK,  '0, 5'd0, 0);
        issue_request(CMD_REMOVE,    '0, 5'd0, 0);
        issue_request(CMD_CLEAR,     '0, 5'd0, 0);

        // Small list with the extreme values, insert in the middle and at the end
        issue_request(CMD_PUSH_FRONT, 32'sh7fff_ffff, 5'd16, 0);
        issue_request(CMD_PUSH_BACK,  32'sh8000_0000, 5'd31, 0);
        issue_request(CMD_INSERT,     -32'sd1,        5'd1,  0);
        issue_request(CMD_INSERT,     32'sh5555_aaaa, 5'd3,  0);
        issue_request(CMD_INSERT,     32'sh1234_5678, 5'd16, 0);
        issue_request(CMD_READ,       '0,             5'd0,  0);
        issue_request(CMD_REMOVE,     '0,             5'd1,  0);
        issue_request(CMD_READ,       '0,             5'd3,  0);
        issue_request(CMD_REMOVE,     '0,             5'd3,  0);
        issue_request(CMD_POP_FRONT,  '0,             5'd0,  0);
        issue_request(CMD_POP_BACK,   '0,             5'd0,  0);

        // Fill to capacity, then hit it with every kind of store
        while (tracker.fill < CAPACITY)
            issue_request(CMD_PUSH_BACK, pick_value(), 5'd0, 0);
        issue_request(CMD_PUSH_FRONT, 32'sh0f0f_0f0f, 5'd0,  0);
        issue_request(CMD_PUSH_BACK,  32'sh0f0f_0f0f, 5'd0,  0);
        issue_request(CMD_INSERT,     32'sh0f0f_0f0f, 5'd16, 0);
        issue_request(CMD_READ,       '0,             5'd15, 0);
        issue_request(CMD_READ,       '0,             5'd16, 0);
        issue_request(CMD_REMOVE,     '0,             5'd15, 0);
        issue_request(CMD_INSERT,     32'sh0f0f_0f0f, 5'd15, 0);
        issue_request(CMD_CLEAR,      '0,             5'd0,  0);
        drain_replies();

        // Light sender idling, then heavy, then back to back
        run_random(300, 15);
        drain_replies();
        run_random(300, 75);
        drain_replies();
        run_random(300, 0);
        drain_replies();

        // Wait for any stray strobe before the final check
        repeat (8) @(posedge clk);
        if (tracker.pending_replies.size() != 0)
        begin
            $error("%0d replies never arrived", tracker.pending_replies.size());
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
